>>> design/failsafe_monitor_top_defines.svh
// Assertion macros shared by the failsafe monitor.
`ifndef FAILSAFE_MONITOR_TOP_DEFINES_SVH
`define FAILSAFE_MONITOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FSMON_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("failsafe monitor check failed");
`define FSMON_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("failsafe monitor reset check failed");
`else
`define FSMON_ASSERT(lbl, clk_s, rst_s, prop)
`define FSMON_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif
`endif

>>> design/fsmon_pkg.sv
package fsmon_pkg;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } divctl_t;

  typedef struct packed {
    logic crit_lt;
    logic low_lt;
  } grade_t;

  localparam logic FUNC_UPDATE  = 1'b0;
  localparam logic FUNC_BATTERY = 1'b1;

  localparam logic [1:0] REG_ACT_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_CELL_LOW    = 2'd1;
  localparam logic [1:0] REG_CELL_CRIT   = 2'd2;
  localparam logic [1:0] REG_OVERCURRENT = 2'd3;

  localparam logic [31:0] ACT_TIMEOUT_RST = 32'd10000;
  localparam logic [15:0] CELL_LOW_RST    = 16'd3300;
  localparam logic [15:0] CELL_CRIT_RST   = 16'd3000;
  localparam logic [30:0] OVERCURRENT_RST = 31'd100000;

  localparam int FLAG_RC   = 0;
  localparam int FLAG_FMU  = 1;
  localparam int FLAG_TO   = 2;
  localparam int FLAG_BATT = 3;

  localparam int WARN_LOW  = 0;
  localparam int WARN_CRIT = 1;
  localparam int WARN_OC   = 2;

  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] CNT_LAST = 5'd31;

endpackage

>>> design/fsmon_divgrade.sv
module fsmon_divgrade
  import fsmon_pkg::*;
(
  input  logic        clk,
  input  divctl_t     ctl,
  input  logic [15:0] pack_mv,
  input  logic [7:0]  cell_num,
  input  logic [15:0] crit_mv,
  input  logic [15:0] low_mv,
  output grade_t      grade
);

  logic [15:0] d_sh_r;
  logic [7:0]  rem_r;
  logic [7:0]  cells_r;
  logic [15:0] cr_sh_r;
  logic [15:0] lo_sh_r;
  logic        crit_dec_r;
  logic        crit_lt_r;
  logic        low_dec_r;
  logic        low_lt_r;

  logic [8:0]  trial;
  logic [8:0]  diff;
  logic        qbit;

  // One quotient bit per cycle while ctl.step is high, most significant first, graded as it appears.
  assign trial = {rem_r, d_sh_r[15]};
  assign diff  = trial - {1'b0, cells_r};
  assign qbit  = (trial >= {1'b0, cells_r});

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      d_sh_r     <= pack_mv;
      rem_r      <= '0;
      cells_r    <= cell_num;
      cr_sh_r    <= crit_mv;
      lo_sh_r    <= low_mv;
      crit_dec_r <= 1'b0;
      crit_lt_r  <= 1'b0;
      low_dec_r  <= 1'b0;
      low_lt_r   <= 1'b0;
    end else if (ctl.step) begin
      d_sh_r  <= {d_sh_r[14:0], 1'b0};
      rem_r   <= qbit ? diff[7:0] : trial[7:0];
      cr_sh_r <= {cr_sh_r[14:0], 1'b0};
      lo_sh_r <= {lo_sh_r[14:0], 1'b0};
      if (!crit_dec_r && (qbit != cr_sh_r[15])) begin
        crit_dec_r <= 1'b1;
        crit_lt_r  <= ~qbit;
      end
      if (!low_dec_r && (qbit != lo_sh_r[15])) begin
        low_dec_r <= 1'b1;
        low_lt_r  <= ~qbit;
      end
    end
  end

  assign grade.crit_lt = crit_lt_r;
  assign grade.low_lt  = low_lt_r;

endmodule

>>> design/failsafe_monitor_top.sv
// Each word is accepted while idle and then passes a 32-step bit-serial run that
// handles the time subtract or current magnitude, the sequence compare, the limit
// compares and the 16-step divider. A new word is not taken until its result is out.
// The output register holds a result while the next word is processed.
// Reset (synchronous, active low) clears the control, flag and output-valid state and restores the registers.
`include "failsafe_monitor_top_defines.svh"
module failsafe_monitor_top
  import fsmon_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic [31:0]        in_now_us,
  input  logic               in_rc_lost_in,
  input  logic               in_fmu_lost_in,
  input  logic               in_cmd_present,
  input  logic [31:0]        in_cmd_seq,
  input  logic [15:0]        in_voltage_mv,
  input  logic signed [31:0] in_current_ma,
  input  logic [7:0]         in_cell_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_battery_warnings,
  output logic [3:0]         out_condition_flags,
  output logic               out_any_active,
  output logic               out_armed_clear,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  state_t           st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r;

  logic [31:0] act_timeout_r;
  logic [15:0] cell_low_r;
  logic [15:0] cell_crit_r;
  logic [30:0] overcurrent_r;

  logic        rc_lost_r, fmu_gone_r, act_to_r, batt_low_r, agg_r;
  logic [31:0] last_time_r, last_seq_r;

  logic        func_r, rc_in_r, fmu_in_r, present_r, sign_r, cells_nz_r;
  logic [31:0] x_sh_r, y_sh_r, p_sh_r, q_sh_r, t_sh_r;
  logic        ne_r, brw_r, seen_r, gt_r;

  logic        out_valid_r;
  logic [2:0]  out_warn_r;
  logic [3:0]  out_flags_r;
  logic        out_any_r;
  logic        out_clear_r;

  logic        accept, fire;
  logic        xb, yb, tb, eb, mb, sb;
  divctl_t     div_ctl;
  grade_t      grade;

  logic        rc_nxt, fmu_nxt, to_nxt, batt_nxt, agg_nxt, pulse_nxt;
  logic [31:0] time_nxt, seq_nxt;
  logic [2:0]  warn_nxt;
  logic [3:0]  flags_nxt;

  assign accept   = in_valid && (st_r == ST_IDLE);
  assign fire     = (st_r == ST_FIN) && (!out_valid_r || !out_stall);
  assign in_stall = (st_r != ST_IDLE);

  assign div_ctl.load = accept;
  assign div_ctl.step = (st_r == ST_RUN) && !cnt_r[CNT_W-1];

  fsmon_divgrade u_divgrade (
    .clk      (clk),
    .ctl      (div_ctl),
    .pack_mv  (in_voltage_mv),
    .cell_num (in_cell_count),
    .crit_mv  (cell_crit_r),
    .low_mv   (cell_low_r),
    .grade    (grade)
  );

  // Serial bit: elapsed time for an update, current magnitude for a battery word.
  assign xb = x_sh_r[0];
  assign yb = y_sh_r[0];
  assign tb = t_sh_r[0];
  assign eb = xb ^ yb ^ brw_r;
  assign mb = xb ^ (sign_r & seen_r);
  assign sb = (func_r == FUNC_BATTERY) ? mb : eb;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_valid) st_nxt = ST_RUN;
      ST_RUN:  if (cnt_r == CNT_LAST) st_nxt = ST_FIN;
      ST_FIN:  if (fire) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rc_nxt    = rc_lost_r;
    fmu_nxt   = fmu_gone_r;
    to_nxt    = act_to_r;
    batt_nxt  = batt_low_r;
    agg_nxt   = agg_r;
    pulse_nxt = 1'b0;
    time_nxt  = last_time_r;
    seq_nxt   = last_seq_r;
    warn_nxt  = '0;
    if (func_r == FUNC_UPDATE) begin
      rc_nxt  = rc_in_r;
      fmu_nxt = fmu_in_r;
      if (present_r) begin
        if (ne_r) begin
          seq_nxt  = p_sh_r;
          time_nxt = x_sh_r;
          to_nxt   = 1'b0;
        end else if (gt_r && !act_to_r) begin
          to_nxt    = 1'b1;
          pulse_nxt = 1'b1;
        end
      end
      agg_nxt = rc_nxt | fmu_nxt | to_nxt | batt_low_r;
    end else begin
      if (cells_nz_r) begin
        if (grade.crit_lt) begin
          warn_nxt[WARN_CRIT] = 1'b1;
          batt_nxt            = 1'b1;
        end else if (grade.low_lt) begin
          warn_nxt[WARN_LOW] = 1'b1;
          batt_nxt           = 1'b1;
        end else begin
          batt_nxt = 1'b0;
        end
      end
      warn_nxt[WARN_OC] = gt_r;
    end
    flags_nxt            = '0;
    flags_nxt[FLAG_RC]   = rc_nxt;
    flags_nxt[FLAG_FMU]  = fmu_nxt;
    flags_nxt[FLAG_TO]   = to_nxt;
    flags_nxt[FLAG_BATT] = batt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= ST_IDLE;
      cnt_r         <= '0;
      act_timeout_r <= ACT_TIMEOUT_RST;
      cell_low_r    <= CELL_LOW_RST;
      cell_crit_r   <= CELL_CRIT_RST;
      overcurrent_r <= OVERCURRENT_RST;
      rc_lost_r     <= 1'b0;
      fmu_gone_r    <= 1'b0;
      act_to_r      <= 1'b0;
      batt_low_r    <= 1'b0;
      agg_r         <= 1'b0;
      last_time_r   <= '0;
      last_seq_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_RUN) begin
        cnt_r <= cnt_r + 1'b1;
      end else begin
        cnt_r <= '0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ACT_TIMEOUT: act_timeout_r <= cfg_wdata;
          REG_CELL_LOW:    cell_low_r    <= cfg_wdata[15:0];
          REG_CELL_CRIT:   cell_crit_r   <= cfg_wdata[15:0];
          REG_OVERCURRENT: overcurrent_r <= cfg_wdata[30:0];
          default:         act_timeout_r <= act_timeout_r;
        endcase
      end
      if (fire) begin
        rc_lost_r   <= rc_nxt;
        fmu_gone_r  <= fmu_nxt;
        act_to_r    <= to_nxt;
        batt_low_r  <= batt_nxt;
        agg_r       <= agg_nxt;
        last_time_r <= time_nxt;
        last_seq_r  <= seq_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r     <= in_func;
      rc_in_r    <= in_rc_lost_in;
      fmu_in_r   <= in_fmu_lost_in;
      present_r  <= in_cmd_present;
      sign_r     <= in_current_ma[31];
      cells_nz_r <= (in_cell_count != '0);
      x_sh_r     <= (in_func == FUNC_BATTERY) ? in_current_ma : in_now_us;
      y_sh_r     <= last_time_r;
      p_sh_r     <= in_cmd_seq;
      q_sh_r     <= last_seq_r;
      t_sh_r     <= (in_func == FUNC_BATTERY) ? {1'b0, overcurrent_r} : act_timeout_r;
      ne_r       <= 1'b0;
      brw_r      <= 1'b0;
      seen_r     <= 1'b0;
      gt_r       <= 1'b0;
    end else if (st_r == ST_RUN) begin
      x_sh_r <= {x_sh_r[0], x_sh_r[31:1]};
      y_sh_r <= {y_sh_r[0], y_sh_r[31:1]};
      p_sh_r <= {p_sh_r[0], p_sh_r[31:1]};
      q_sh_r <= {q_sh_r[0], q_sh_r[31:1]};
      t_sh_r <= {t_sh_r[0], t_sh_r[31:1]};
      ne_r   <= ne_r | (p_sh_r[0] ^ q_sh_r[0]);
      brw_r  <= (~xb & yb) | (~(xb ^ yb) & brw_r);
      seen_r <= seen_r | xb;
      gt_r   <= (sb & ~tb) | (gt_r & ~(sb ^ tb));
    end
    if (fire) begin
      out_warn_r  <= warn_nxt;
      out_flags_r <= flags_nxt;
      out_any_r   <= agg_nxt;
      out_clear_r <= pulse_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_battery_warnings = out_warn_r;
  assign out_condition_flags  = out_flags_r;
  assign out_any_active       = out_any_r;
  assign out_armed_clear      = out_clear_r;

  `FSMON_ASSERT(a_start_run, clk, rst_n, accept |=> st_r == ST_RUN && cnt_r == '0)
  `FSMON_ASSERT(a_clear_flags, clk, rst_n,
                out_valid && out_armed_clear |->
                out_condition_flags[FLAG_TO] && out_battery_warnings == '0)
  `FSMON_ASSERT(a_fire_once, clk, rst_n, fire |=> st_r == ST_IDLE && out_valid)
  `FSMON_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid && st_r == ST_IDLE)

endmodule

>>> tb/failsafe_monitor_top_tb.sv
`timescale 1ns / 100ps

module failsafe_monitor_top_tb
  import fsmon_pkg::*;
();

  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic        func;
    logic [31:0] now_us;
    logic        rc_lost;
    logic        fmu_gone;
    logic        cmd_present;
    logic [31:0] cmd_seq;
    logic [15:0] pack_mv;
    logic [31:0] pack_ma;
    logic [7:0]  cell_num;
  } word_t;

  typedef struct packed {
    logic [2:0] warnings;
    logic [3:0] flags;
    logic       active;
    logic       disarm;
  } report_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_func = 1'b0;
  logic [31:0]        in_now_us = '0;
  logic               in_rc_lost_in = 1'b0;
  logic               in_fmu_lost_in = 1'b0;
  logic               in_cmd_present = 1'b0;
  logic [31:0]        in_cmd_seq = '0;
  logic [15:0]        in_voltage_mv = '0;
  logic signed [31:0] in_current_ma = '0;
  logic [7:0]         in_cell_count = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_battery_warnings;
  logic [3:0]         out_condition_flags;
  logic               out_any_active;
  logic               out_armed_clear;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_wdata = '0;

  logic [31:0] lim_actuator_us = ACT_TIMEOUT_RST;
  logic [15:0] lim_cell_low = CELL_LOW_RST;
  logic [15:0] lim_cell_crit = CELL_CRIT_RST;
  logic [30:0] lim_overcurrent = OVERCURRENT_RST;

  logic        rc_down = 1'b0;
  logic        fmu_down = 1'b0;
  logic        watchdog_tripped = 1'b0;
  logic        pack_low = 1'b0;
  logic        failsafe_on = 1'b0;
  logic [31:0] cmd_stamp = '0;
  logic [31:0] cmd_seen_seq = '0;

  logic [31:0] gen_stamp = '0;
  logic [31:0] gen_seq = '0;
  logic [31:0] gen_elapsed = '0;

  word_t   words_to_send[$];
  report_t awaited_reports[$];
  word_t   held_word;
  bit      sending = 1'b0;
  int      tx_gap = 0;
  int      tx_burst = 0;
  bit      tx_calm = 1'b0;
  int      rx_hold = 0;
  int      rx_burst = 0;
  bit      rx_calm = 1'b0;
  report_t want;
  int      mismatches = 0;

  failsafe_monitor_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_now_us(in_now_us),
    .in_rc_lost_in(in_rc_lost_in),
    .in_fmu_lost_in(in_fmu_lost_in),
    .in_cmd_present(in_cmd_present),
    .in_cmd_seq(in_cmd_seq),
    .in_voltage_mv(in_voltage_mv),
    .in_current_ma(in_current_ma),
    .in_cell_count(in_cell_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_battery_warnings(out_battery_warnings),
    .out_condition_flags(out_condition_flags),
    .out_any_active(out_any_active),
    .out_armed_clear(out_armed_clear),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic report_t failsafe_response(input word_t w);
    report_t     r;
    logic [31:0] elapsed;
    logic [15:0] per_cell;
    logic [32:0] magnitude;
    r = '0;
    if (w.func == FUNC_UPDATE) begin
      rc_down = w.rc_lost;
      fmu_down = w.fmu_gone;
      if (w.cmd_present) begin
        elapsed = w.now_us - cmd_stamp;
        if (w.cmd_seq != cmd_seen_seq) begin
          cmd_seen_seq = w.cmd_seq;
          cmd_stamp = w.now_us;
          watchdog_tripped = 1'b0;
        end else if (elapsed > lim_actuator_us && !watchdog_tripped) begin
          watchdog_tripped = 1'b1;
          r.disarm = 1'b1;
        end
      end
      failsafe_on = rc_down | fmu_down | watchdog_tripped | pack_low;
    end else begin
      if (w.cell_num != 8'd0) begin
        per_cell = w.pack_mv / w.cell_num;
        if (per_cell < lim_cell_crit) begin
          r.warnings[WARN_CRIT] = 1'b1;
          pack_low = 1'b1;
        end else if (per_cell < lim_cell_low) begin
          r.warnings[WARN_LOW] = 1'b1;
          pack_low = 1'b1;
        end else begin
          pack_low = 1'b0;
        end
      end
      magnitude = w.pack_ma[31] ? {1'b0, ~w.pack_ma} + 33'd1 : {1'b0, w.pack_ma};
      if (magnitude > {2'b00, lim_overcurrent}) r.warnings[WARN_OC] = 1'b1;
    end
    r.flags[FLAG_RC] = rc_down;
    r.flags[FLAG_FMU] = fmu_down;
    r.flags[FLAG_TO] = watchdog_tripped;
    r.flags[FLAG_BATT] = pack_low;
    r.active = failsafe_on;
    return r;
  endfunction

  function automatic word_t random_word();
    word_t w;
    w.func = 1'($urandom);
    w.now_us = $urandom;
    w.rc_lost = 1'($urandom);
    w.fmu_gone = 1'($urandom);
    w.cmd_present = 1'($urandom);
    w.cmd_seq = $urandom;
    w.pack_mv = 16'($urandom);
    w.pack_ma = $urandom;
    w.cell_num = 8'($urandom);
    return w;
  endfunction

  function automatic word_t update_word(input logic [31:0] now, input logic rc,
                                        input logic fmu, input logic present,
                                        input logic [31:0] seq);
    word_t w;
    w = random_word();
    w.func = FUNC_UPDATE;
    w.now_us = now;
    w.rc_lost = rc;
    w.fmu_gone = fmu;
    w.cmd_present = present;
    w.cmd_seq = seq;
    return w;
  endfunction

  function automatic word_t battery_word(input logic [15:0] volts, input logic [31:0] amps,
                                         input logic [7:0] cells);
    word_t w;
    w = random_word();
    w.func = FUNC_BATTERY;
    w.pack_mv = volts;
    w.pack_ma = amps;
    w.cell_num = cells;
    return w;
  endfunction

  task automatic compare_field(input string field, input logic [3:0] expected_v,
                               input logic [3:0] actual_v);
    if (expected_v !== actual_v) begin
      mismatches++;
      $display("%0t: %s expected %0d, actual %0d", $time, field, expected_v, actual_v);
    end
  endtask

  task automatic set_register(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_ACT_TIMEOUT: lim_actuator_us = data;
      REG_CELL_LOW:    lim_cell_low = data[15:0];
      REG_CELL_CRIT:   lim_cell_crit = data[15:0];
      REG_OVERCURRENT: lim_overcurrent = data[30:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_limits(input logic [31:0] timeout_us, input logic [15:0] low_mv,
                              input logic [15:0] crit_mv, input logic [30:0] oc_ma);
    set_register(REG_ACT_TIMEOUT, timeout_us);
    set_register(REG_CELL_LOW, {16'($urandom), low_mv});
    set_register(REG_CELL_CRIT, {16'($urandom), crit_mv});
    set_register(REG_OVERCURRENT, {1'($urandom), oc_ma});
  endtask

  task automatic settle();
    while (words_to_send.size() != 0 || sending || awaited_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random_words(input int count);
    word_t       w;
    int          pick;
    int          cells;
    int          level;
    int          volts;
    logic [31:0] amps;
    logic [31:0] now;
    repeat (count) begin
      if ($urandom_range(0, 99) < 55) begin
        pick = $urandom_range(0, 19);
        if (pick < 3) begin
          gen_seq = $urandom_range(0, 1) ? gen_seq + 32'd1 : $urandom;
          gen_stamp = $urandom_range(0, 1) ? gen_stamp + gen_elapsed : $urandom;
          gen_elapsed = '0;
          now = gen_stamp;
        end else if (pick < 6) begin
          now = gen_stamp + lim_actuator_us + $urandom_range(0, 1);
        end else if (pick < 18) begin
          gen_elapsed = gen_elapsed + $urandom_range(0, lim_actuator_us / 3 + 1);
          now = gen_stamp + gen_elapsed;
        end else begin
          now = $urandom;
        end
        w = update_word(now, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                        $urandom_range(0, 9) != 0, gen_seq);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick == 0) cells = 0;
        else if (pick == 1) cells = $urandom_range(1, 255);
        else cells = $urandom_range(1, 12);
        pick = $urandom_range(0, 5);
        if (pick == 0) level = int'(lim_cell_crit) + int'($urandom_range(0, 2)) - 1;
        else if (pick == 1) level = int'(lim_cell_low) + int'($urandom_range(0, 2)) - 1;
        else level = $urandom_range(0, 65535 / (cells == 0 ? 1 : cells));
        volts = (cells == 0) ? -1 : level * cells + int'($urandom_range(0, cells - 1));
        if (volts < 0 || volts > 65535) volts = $urandom_range(0, 65535);
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          amps = {1'b0, lim_overcurrent} + $urandom_range(0, 2) - 32'd1;
          if ($urandom_range(0, 1) == 1) amps = -amps;
        end else if (pick == 4) begin
          amps = 32'h8000_0000;
        end else if (pick == 5) begin
          amps = 32'h7FFF_FFFF;
        end else begin
          amps = $urandom;
        end
        w = battery_word(16'(volts), amps, 8'(cells));
      end
      words_to_send.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sending = 1'b0;
      tx_gap = 0;
      in_valid <= 1'b0;
    end else begin
      if (sending && !in_stall) begin
        awaited_reports.push_back(failsafe_response(held_word));
        sending = 1'b0;
        if (tx_burst == 0) begin
          tx_calm = ($urandom_range(0, 3) == 0);
          tx_burst = $urandom_range(8, 64);
        end
        tx_burst--;
        tx_gap = tx_calm ? 0 : $urandom_range(0, 18);
      end
      if (!sending) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (words_to_send.size() != 0) begin
          held_word = words_to_send.pop_front();
          sending = 1'b1;
          in_func <= held_word.func;
          in_now_us <= held_word.now_us;
          in_rc_lost_in <= held_word.rc_lost;
          in_fmu_lost_in <= held_word.fmu_gone;
          in_cmd_present <= held_word.cmd_present;
          in_cmd_seq <= held_word.cmd_seq;
          in_voltage_mv <= held_word.pack_mv;
          in_current_ma <= held_word.pack_ma;
          in_cell_count <= held_word.cell_num;
        end
      end
      in_valid <= sending;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_reports.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: warnings %0d flags %0d any %0d clear %0d",
                   $time, out_battery_warnings, out_condition_flags, out_any_active,
                   out_armed_clear);
        end else begin
          want = awaited_reports.pop_front();
          compare_field("battery_warnings", 4'(want.warnings), 4'(out_battery_warnings));
          compare_field("condition_flags", want.flags, out_condition_flags);
          compare_field("any_active", 4'(want.active), 4'(out_any_active));
          compare_field("armed_clear", 4'(want.disarm), 4'(out_armed_clear));
        end
        if (rx_burst == 0) begin
          rx_calm = ($urandom_range(0, 3) == 0);
          rx_burst = $urandom_range(8, 64);
        end
        rx_burst--;
        rx_hold = rx_calm ? 0 : $urandom_range(0, 18);
      end else if (out_valid && rx_hold > 0) begin
        rx_hold--;
      end
      out_stall <= (rx_hold > 0);
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Watchdog boundaries, wrap of the time counter and the grading edges at reset limits.
    words_to_send.push_back(update_word(32'd0, 1'b0, 1'b0, 1'b1, 32'd0));
    words_to_send.push_back(update_word(32'd10000, 1'b1, 1'b0, 1'b1, 32'd0));
    words_to_send.push_back(update_word(32'd10001, 1'b0, 1'b1, 1'b1, 32'd0));
    words_to_send.push_back(update_word(32'd20000, 1'b0, 1'b0, 1'b1, 32'd0));
    words_to_send.push_back(update_word(32'd5, 1'b1, 1'b1, 1'b0, 32'd5));
    words_to_send.push_back(update_word(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 32'd5));
    words_to_send.push_back(update_word(32'd9999, 1'b0, 1'b0, 1'b1, 32'd5));
    words_to_send.push_back(update_word(32'd10000, 1'b0, 1'b0, 1'b1, 32'd5));
    words_to_send.push_back(battery_word(16'hFFFF, 32'h8000_0000, 8'd0));
    words_to_send.push_back(battery_word(16'd11999, 32'd100000, 8'd4));
    words_to_send.push_back(battery_word(16'd12000, 32'd100001, 8'd4));
    words_to_send.push_back(battery_word(16'd3300, -32'd100001, 8'd1));
    words_to_send.push_back(battery_word(16'd0, 32'h7FFF_FFFF, 8'd255));
    words_to_send.push_back(battery_word(16'd9899, -32'd100000, 8'd3));
    words_to_send.push_back(update_word(32'd123, 1'b0, 1'b0, 1'b0, 32'd0));
    words_to_send.push_back(battery_word(16'hFFFF, 32'd0, 8'd2));
    words_to_send.push_back(update_word(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF));
    words_to_send.push_back(update_word(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF));
    words_to_send.push_back(update_word(32'h7FFF_0000, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF));
    settle();

    apply_limits(32'd1, 16'hFFFF, 16'h0000, 31'd0);
    queue_random_words(250);
    settle();

    apply_limits(32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 31'h7FFF_FFFF);
    queue_random_words(250);
    settle();

    apply_limits(ACT_TIMEOUT_RST, CELL_LOW_RST, CELL_CRIT_RST, OVERCURRENT_RST);
    queue_random_words(260);
    settle();

    for (int phase = 0; phase < 3; phase++) begin
      automatic logic [15:0] low_mv = 16'($urandom_range(2000, 4500));
      apply_limits(phase == 2 ? $urandom : $urandom_range(200, 40000), low_mv,
                   16'($urandom_range(1500, low_mv)), 31'($urandom_range(0, 300000)));
      queue_random_words(260);
      settle();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/fsmon_pkg.sv
design/fsmon_divgrade.sv
design/failsafe_monitor_top.sv
tb/failsafe_monitor_top_tb.sv
